// File: hdl/lbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbpc_pkg;

    localparam int PERIOD_W = 20;
    localparam int REMAIN_W = 21;
    localparam int OPCODE_W = 3;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ON    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_OFF   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SLOW  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUICK = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_COUNT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUICK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_PERIOD = 2'd2;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST  = 20'd500000;
    localparam logic [PERIOD_W-1:0] QUICK_PERIOD_RST = 20'd100000;
    localparam logic [PERIOD_W-1:0] COUNT_PERIOD_RST = 20'd200000;
    localparam logic [REMAIN_W-1:0] IDLE_DELAY       = 21'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_SLOW  = 3'd2,
        MODE_QUICK = 3'd3,
        MODE_COUNT = 3'd4
    } t_mode;

endpackage

`default_nettype wire

// File: hdl/lbpc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface lbpc_cmd_if #(
    parameter int TARGET_WIDTH = 8
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              opcode;
    logic [TARGET_WIDTH-1:0] blink_target;

    modport source (output valid, output opcode, output blink_target, input ready);
    modport sink   (input valid, input opcode, input blink_target, output ready);
endinterface

interface lbpc_status_if #(
    parameter int TARGET_WIDTH = 8
);
    logic                  valid;
    logic                  ready;
    logic                  led_level;
    logic [2:0]            mode;
    logic [TARGET_WIDTH:0] toggle_count;

    modport source (output valid, output led_level, output mode, output toggle_count,
                    input ready);
    modport sink   (input valid, input led_level, input mode, input toggle_count,
                    output ready);
endinterface

interface lbpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/led_blink_pattern_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                                  Accept
// i_cmd      in   opcode, blink_target                     valid & ready
// o_status   out  led_level, mode, toggle_count            valid & ready
// i_cfg      in   index, data (slow/quick/count period)    valid & ready (ready always 1)
//
// One item per cycle while no result is held. An item is captured in the input
// register, then the state registers update; those double as the result register.
// Reset (i_rst_n low, synchronous) returns to off, dark, count 0, periods default.
// A held result stalls the input register; an item still lands there if it is empty.

module led_blink_pattern_controller #(
    parameter int TARGET_WIDTH = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lbpc_cmd_if.sink     i_cmd,
    lbpc_status_if.source o_status,
    lbpc_cfg_if.sink     i_cfg
);
    import lbpc_pkg::*;

    localparam int CNT_W = TARGET_WIDTH + 1;

    logic [PERIOD_W-1:0]     r_slow, r_quick, r_cnt_per;
    logic                    r_in_valid;
    logic [OPCODE_W-1:0]     r_in_op;
    logic [TARGET_WIDTH-1:0] r_in_tgt;
    logic                    r_out_valid;
    t_mode                   r_mode, n_mode;
    logic                    r_led, n_led;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [TARGET_WIDTH-1:0] r_target, n_target;
    logic [REMAIN_W-1:0]     r_remain, n_remain;
    logic                    w_adv, w_fire;

    function automatic logic [REMAIN_W-1:0] delay_for(
        input t_mode m, input logic [CNT_W-1:0] c,
        input logic [PERIOD_W-1:0] slow, input logic [PERIOD_W-1:0] quick,
        input logic [PERIOD_W-1:0] cper);
        logic [REMAIN_W-1:0] d;
        begin
            unique case (m)
                MODE_SLOW:  d = {1'b0, slow};
                MODE_QUICK: d = {1'b0, quick};
                MODE_COUNT: d = (c == '0) ? {cper, 1'b0} : {1'b0, cper};
                default:    d = IDLE_DELAY;
            endcase
            return d;
        end
    endfunction

    function automatic logic is_blink(input t_mode m);
        return (m == MODE_SLOW) || (m == MODE_QUICK) || (m == MODE_COUNT);
    endfunction

    assign w_adv         = !r_out_valid || o_status.ready;
    assign w_fire        = r_in_valid && w_adv;
    assign i_cmd.ready   = !r_in_valid || w_adv;
    assign i_cfg.ready   = 1'b1;

    assign o_status.valid        = r_out_valid;
    assign o_status.led_level    = r_led;
    assign o_status.mode         = r_mode;
    assign o_status.toggle_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow    <= SLOW_PERIOD_RST;
            r_quick   <= QUICK_PERIOD_RST;
            r_cnt_per <= COUNT_PERIOD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SLOW_PERIOD:  r_slow    <= i_cfg.data;
                REG_QUICK_PERIOD: r_quick   <= i_cfg.data;
                REG_COUNT_PERIOD: r_cnt_per <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_op  <= i_cmd.opcode;
            r_in_tgt <= i_cmd.blink_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_status.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_led    <= 1'b0;
            r_count  <= '0;
            r_target <= '0;
            r_remain <= '0;
        end else if (w_fire) begin
            r_mode   <= n_mode;
            r_led    <= n_led;
            r_count  <= n_count;
            r_target <= n_target;
            r_remain <= n_remain;
        end
    end

    always_comb begin
        t_mode               e_mode;
        logic [CNT_W-1:0]    e_cnt;
        logic [CNT_W-1:0]    c_inc;
        logic [REMAIN_W-1:0] d_enter;
        logic [REMAIN_W-1:0] d_tick;
        logic                e_go;

        n_mode   = r_mode;
        n_led    = r_led;
        n_count  = r_count;
        n_target = r_target;
        n_remain = r_remain;

        e_mode = (r_in_op == OP_SLOW)  ? MODE_SLOW :
                 (r_in_op == OP_QUICK) ? MODE_QUICK : MODE_COUNT;
        if ((r_in_op == OP_COUNT) && is_blink(r_mode)) begin
            e_cnt = r_led ? '0 : CNT_W'(1);
        end else begin
            e_cnt = '0;
        end
        e_go    = 1'b0;
        d_enter = delay_for(e_mode, e_cnt, r_slow, r_quick, r_cnt_per);
        d_tick  = delay_for(r_mode, r_count, r_slow, r_quick, r_cnt_per);
        c_inc   = r_count + CNT_W'(1);

        unique case (r_in_op) inside
            OP_TICK: begin
                if (is_blink(r_mode)) begin
                    if (r_remain[REMAIN_W-1:1] == '0) begin
                        n_remain = d_tick;
                        n_led    = !r_led;
                        if (r_mode == MODE_COUNT) begin
                            n_count = ({r_target, 1'b0} <= c_inc) ? '0 : c_inc;
                        end
                    end else begin
                        n_remain = r_remain - REMAIN_W'(1);
                    end
                end
            end
            OP_ON: begin
                if (r_mode != MODE_ON) begin
                    n_mode = MODE_ON;
                    n_led  = 1'b1;
                end
            end
            OP_OFF: begin
                if (r_mode != MODE_OFF) begin
                    n_mode = MODE_OFF;
                    n_led  = 1'b0;
                end
            end
            OP_SLOW, OP_QUICK: begin
                e_go = (r_mode != e_mode);
            end
            OP_COUNT: begin
                n_target = r_in_tgt;
                n_count  = r_led ? '0 : CNT_W'(1);
                e_go     = (r_mode != MODE_COUNT);
            end
            default: ;
        endcase

        if (e_go) begin
            n_mode  = e_mode;
            n_count = e_cnt;
            if (is_blink(r_mode) && (r_remain > d_enter)) begin
                n_remain = r_remain - d_enter;
            end else begin
                n_remain = d_enter;
                n_led    = !r_led;
            end
        end
    end

    a_on_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ON) |-> r_led)
        else $error("on mode with LED dark");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OFF) |-> !r_led)
        else $error("off mode with LED lit");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed item produced no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_COUNT) |-> ((r_count < {r_target, 1'b0}) || (r_count <= CNT_W'(1))))
        else $error("toggle count past group end");

endmodule

`default_nettype wire
